// ----- rtl/core/scrr_pkg.sv -----
// Shared types, codes and defaults for the sequenced channel receive reorder block.
package scrr_pkg;

  localparam int NUM_STREAMS_DEFAULT    = 8;
  localparam int REORDER_WINDOW_DEFAULT = 16;

  localparam int STREAM_W = 3;
  localparam int SEQ_W    = 32;
  localparam int ID_W     = 16;
  localparam int TAG_W    = 16;

  // channel_mode register values
  localparam logic [1:0] MODE_UNREL_UNORD = 2'd0;
  localparam logic [1:0] MODE_UNREL_ORD   = 2'd1;
  localparam logic [1:0] MODE_REL_UNORD   = 2'd2;
  localparam logic [1:0] MODE_REL_ORD     = 2'd3;

  // result_kind values
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // result source select
  localparam logic [2:0] EMIT_DELIVER_IN   = 3'd0;
  localparam logic [2:0] EMIT_ACK_IN       = 3'd1;
  localparam logic [2:0] EMIT_ACK_NEXT     = 3'd2;
  localparam logic [2:0] EMIT_DELIVER_SLOT = 3'd3;
  localparam logic [2:0] EMIT_ACK_DRAIN    = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  message_id;
    logic [TAG_W-1:0] payload_tag;
  } slot_word_t;

  localparam int SLOT_WORD_W = $bits(slot_word_t);

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       emit;
    logic [2:0] emit_sel;
    logic       emit_last;
    logic       wr_last_acc;
    logic       wr_slot;
    logic       start_drain;
    logic       drain_step;
    logic       wr_next;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       st_ok;
    logic [1:0] mode;
    logic       newer;
    logic       seq_lt;
    logic       seq_gt;
    logic       in_window;
    logic       slot_valid;
    logic       cnt_below;
    logic       out_free;
  } status_t;

endpackage

// ----- rtl/core/scrr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module scrr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/scrr_ctrl.sv -----
// Sequencer for the receive reorder block: clearing pass, per-mode decisions, drain loop.
module scrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  scrr_pkg::status_t sts,
  output scrr_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_SECOND = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    msg_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        msg_stall = 1'b0;
        if (msg_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.st_ok) begin
          // stream out of range: drop without results
          state_next = ST_IDLE;
        end else begin
          unique case (sts.mode)
            scrr_pkg::MODE_UNREL_UNORD: begin
              if (sts.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = scrr_pkg::EMIT_DELIVER_IN;
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
              end
            end
            scrr_pkg::MODE_UNREL_ORD: begin
              if (!sts.newer) begin
                state_next = ST_IDLE;
              end else if (sts.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_sel    = scrr_pkg::EMIT_DELIVER_IN;
                cmd.emit_last   = 1'b1;
                cmd.wr_last_acc = 1'b1;
                state_next      = ST_IDLE;
              end
            end
            scrr_pkg::MODE_REL_UNORD: begin
              if (sts.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = scrr_pkg::EMIT_ACK_IN;
                state_next   = ST_SECOND;
              end
            end
            scrr_pkg::MODE_REL_ORD: begin
              if (sts.out_free) begin
                cmd.emit = 1'b1;
                priority if (sts.seq_lt) begin
                  cmd.emit_sel  = scrr_pkg::EMIT_ACK_NEXT;
                  cmd.emit_last = 1'b1;
                  state_next    = ST_IDLE;
                end else if (sts.seq_gt) begin
                  // store inside the window, drop beyond it; ack either way
                  cmd.wr_slot   = sts.in_window;
                  cmd.emit_sel  = scrr_pkg::EMIT_ACK_NEXT;
                  cmd.emit_last = 1'b1;
                  state_next    = ST_IDLE;
                end else begin
                  cmd.emit_sel    = scrr_pkg::EMIT_DELIVER_IN;
                  cmd.start_drain = 1'b1;
                  state_next      = ST_DRAIN;
                end
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_SECOND: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = scrr_pkg::EMIT_DELIVER_IN;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.slot_valid && sts.cnt_below) begin
            cmd.emit_sel   = scrr_pkg::EMIT_DELIVER_SLOT;
            cmd.drain_step = 1'b1;
          end else begin
            // close the run with a cumulative ack and commit the stream state
            cmd.emit_sel  = scrr_pkg::EMIT_ACK_DRAIN;
            cmd.emit_last = 1'b1;
            cmd.wr_next   = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result issued while the output register is still occupied");

  a_drain_close: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && cmd.emit && !cmd.drain_step) |=> (state == ST_IDLE && !cmd.emit))
    else $error("drain did not return to idle after its closing ack");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (msg_stall && !cmd.load))
    else $error("new beat taken while an item is still in progress");

endmodule

// ----- rtl/core/scrr_dpath.sv -----
// Datapath: item and drain registers, stream-state and slot RAMs, output register.
module scrr_dpath #(
  parameter int NUM_STREAMS    = scrr_pkg::NUM_STREAMS_DEFAULT,
  parameter int REORDER_WINDOW = scrr_pkg::REORDER_WINDOW_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  scrr_pkg::cmd_t              cmd,
  output scrr_pkg::status_t           sts,
  input  logic [scrr_pkg::STREAM_W-1:0] stream_index,
  input  logic [scrr_pkg::SEQ_W-1:0]  msg_sequence,
  input  logic [scrr_pkg::ID_W-1:0]   message_id,
  input  logic [scrr_pkg::TAG_W-1:0]  payload_tag,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_wr_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic                        result_kind,
  output logic [scrr_pkg::STREAM_W-1:0] out_stream,
  output logic [scrr_pkg::SEQ_W-1:0]  out_sequence,
  output logic [scrr_pkg::ID_W-1:0]   out_message_id,
  output logic [scrr_pkg::TAG_W-1:0]  out_payload_tag,
  output logic                        last_of_run
);

  localparam int SW    = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int SLOTS = NUM_STREAMS * REORDER_WINDOW;
  localparam int AW    = $clog2(SLOTS);
  localparam int MW    = $clog2(REORDER_WINDOW);
  localparam int CW    = $clog2(REORDER_WINDOW + 1);
  localparam int QW    = scrr_pkg::SEQ_W;
  localparam int WORD  = 2 * QW + MW;

  function automatic logic [MW-1:0] mod_inc(input logic [MW-1:0] x);
    return (x == MW'(REORDER_WINDOW - 1)) ? '0 : x + MW'(1);
  endfunction

  // item registers
  logic [scrr_pkg::STREAM_W-1:0] st_reg;
  logic [QW-1:0]                 seq_reg;
  logic [scrr_pkg::ID_W-1:0]     id_reg;
  logic [scrr_pkg::TAG_W-1:0]    tag_reg;
  logic [1:0]                    mode;

  // drain registers
  logic [QW-1:0] nx_reg;
  logic [MW-1:0] cur_mod;
  logic [MW-1:0] cur_mod_next;
  logic [CW-1:0] cnt;
  logic [AW-1:0] clr_cnt;

  logic [SW+2:0] st_wide;
  logic [SW+2:0] in_wide;
  logic [SW-1:0] st_idx;
  logic [SW-1:0] in_idx;
  logic [AW-1:0] base;

  // stream-state RAM: {next_expected, next_expected mod window, last_accepted}
  logic             sram_we;
  logic [SW-1:0]    sram_waddr;
  logic [SW-1:0]    sram_raddr;
  logic [WORD-1:0]  sram_wdata;
  logic [WORD-1:0]  sram_rdata;
  logic [QW-1:0]    nx_ram;
  logic [MW-1:0]    nxmod_ram;
  logic [QW-1:0]    la_ram;

  logic                                slot_we;
  logic [AW-1:0]                       slot_waddr;
  logic [AW-1:0]                       slot_raddr;
  scrr_pkg::slot_word_t                slot_wdata;
  logic [scrr_pkg::SLOT_WORD_W-1:0]    slot_rvec;
  scrr_pkg::slot_word_t                slot_rd;

  logic [QW-1:0] diff_nx;
  logic [QW-1:0] diff_la;
  logic [MW:0]   store_sum;
  logic [MW-1:0] store_mod;

  logic                          res_kind_next;
  logic [QW-1:0]                 res_seq_next;
  logic [scrr_pkg::ID_W-1:0]     res_id_next;
  logic [scrr_pkg::TAG_W-1:0]    res_tag_next;

  assign st_wide = {{SW{1'b0}}, st_reg};
  assign in_wide = {{SW{1'b0}}, stream_index};
  assign st_idx  = st_wide[SW-1:0];
  assign in_idx  = in_wide[SW-1:0];
  assign base    = AW'(st_idx) * AW'(REORDER_WINDOW);

  assign nx_ram    = sram_rdata[WORD-1 -: QW];
  assign nxmod_ram = sram_rdata[QW +: MW];
  assign la_ram    = sram_rdata[QW-1:0];
  assign slot_rd   = slot_rvec;

  // offset of a future sequence folded onto the stream's ring of slots
  assign diff_nx   = seq_reg - nx_ram;
  assign diff_la   = seq_reg - la_ram;
  assign store_sum = (MW+1)'(nxmod_ram) + (MW+1)'(diff_nx[MW-1:0]);
  assign store_mod = (store_sum >= (MW+1)'(REORDER_WINDOW))
                   ? MW'(store_sum - (MW+1)'(REORDER_WINDOW)) : store_sum[MW-1:0];

  // next ring position: advance on a drain step, restarting at zero when the sequence wraps to zero
  always_comb begin
    cur_mod_next = cur_mod;
    if (cmd.start_drain) begin
      cur_mod_next = (&seq_reg) ? '0 : mod_inc(nxmod_ram);
    end else if (cmd.drain_step) begin
      cur_mod_next = (&nx_reg) ? '0 : mod_inc(cur_mod);
    end
  end

  // status toward the sequencer
  always_comb begin
    sts            = '0;
    sts.clear_done = (clr_cnt == AW'(SLOTS - 1));
    sts.st_ok      = (QW'(st_reg) < QW'(NUM_STREAMS));
    sts.mode       = mode;
    sts.newer      = (diff_la != '0) && !diff_la[QW-1];
    sts.seq_lt     = (seq_reg < nx_ram);
    sts.seq_gt     = (seq_reg > nx_ram);
    sts.in_window  = (diff_nx < QW'(REORDER_WINDOW));
    sts.slot_valid = slot_rd.valid;
    sts.cnt_below  = (cnt < CW'(REORDER_WINDOW));
    sts.out_free   = !res_valid || !res_stall;
  end

  // stream-state RAM port control
  always_comb begin
    sram_we    = 1'b0;
    sram_waddr = st_idx;
    sram_wdata = {nx_ram, nxmod_ram, la_ram};
    sram_raddr = cmd.load ? in_idx : st_idx;
    priority if (cmd.clear) begin
      sram_we    = (clr_cnt < AW'(NUM_STREAMS));
      sram_waddr = clr_cnt[SW-1:0];
      sram_wdata = {QW'(1), MW'(1), QW'(0)};
    end else if (cmd.wr_last_acc) begin
      sram_we    = 1'b1;
      sram_wdata = {nx_ram, nxmod_ram, seq_reg};
    end else if (cmd.wr_next) begin
      sram_we    = 1'b1;
      sram_wdata = {nx_reg, cur_mod, la_ram};
    end
  end

  // slot RAM port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = base + AW'(cur_mod);
    slot_wdata = '0;
    slot_raddr = base + AW'(cur_mod_next);
    priority if (cmd.clear) begin
      slot_we    = 1'b1;
      slot_waddr = clr_cnt;
    end else if (cmd.wr_slot) begin
      slot_we    = 1'b1;
      slot_waddr = base + AW'(store_mod);
      slot_wdata = '{valid: 1'b1, message_id: id_reg, payload_tag: tag_reg};
    end else if (cmd.drain_step) begin
      // release the entry just delivered
      slot_we = 1'b1;
    end
  end

  scrr_ram #(
    .WIDTH (WORD),
    .DEPTH (NUM_STREAMS)
  ) u_stream_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  scrr_ram #(
    .WIDTH (scrr_pkg::SLOT_WORD_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rvec)
  );

  always_comb begin
    res_kind_next = scrr_pkg::KIND_DELIVER;
    res_seq_next  = seq_reg;
    res_id_next   = id_reg;
    res_tag_next  = tag_reg;
    unique case (cmd.emit_sel)
      scrr_pkg::EMIT_DELIVER_IN: begin
        res_kind_next = scrr_pkg::KIND_DELIVER;
      end
      scrr_pkg::EMIT_ACK_IN: begin
        res_kind_next = scrr_pkg::KIND_ACK;
        res_id_next   = '0;
        res_tag_next  = '0;
      end
      scrr_pkg::EMIT_ACK_NEXT: begin
        res_kind_next = scrr_pkg::KIND_ACK;
        res_seq_next  = nx_ram - QW'(1);
        res_id_next   = '0;
        res_tag_next  = '0;
      end
      scrr_pkg::EMIT_DELIVER_SLOT: begin
        res_seq_next = nx_reg;
        res_id_next  = slot_rd.message_id;
        res_tag_next = slot_rd.payload_tag;
      end
      scrr_pkg::EMIT_ACK_DRAIN: begin
        res_kind_next = scrr_pkg::KIND_ACK;
        res_seq_next  = nx_reg - QW'(1);
        res_id_next   = '0;
        res_tag_next  = '0;
      end
      default: begin
        res_kind_next = scrr_pkg::KIND_DELIVER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      mode      <= scrr_pkg::MODE_UNREL_UNORD;
      clr_cnt   <= '0;
    end else begin
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_reg  <= stream_index;
      seq_reg <= msg_sequence;
      id_reg  <= message_id;
      tag_reg <= payload_tag;
    end
    if (cmd.start_drain) begin
      nx_reg <= seq_reg + QW'(1);
      cnt    <= CW'(1);
    end else if (cmd.drain_step) begin
      nx_reg <= nx_reg + QW'(1);
      cnt    <= cnt + CW'(1);
    end
    cur_mod <= cur_mod_next;
    if (cmd.emit) begin
      result_kind     <= res_kind_next;
      out_stream      <= st_reg;
      out_sequence    <= res_seq_next;
      out_message_id  <= res_id_next;
      out_payload_tag <= res_tag_next;
      last_of_run     <= cmd.emit_last;
    end
  end

  a_drain_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |-> (cnt < CW'(REORDER_WINDOW)))
    else $error("drain ran past the reorder window");

  a_drain_held: assert property (@(posedge clk) disable iff (rst)
    cmd.drain_step |-> slot_rd.valid)
    else $error("drain delivered a slot that holds no message");

endmodule

// ----- rtl/core/sequenced_channel_receive_reorder_top.sv -----
// Top level of the sequenced channel receive reorder block.
//
//  channel   handshake              payload
//  message   msg_valid / msg_stall  stream_index, msg_sequence, message_id, payload_tag
//  result    res_valid / res_stall  result_kind, out_stream, out_sequence, out_message_id,
//                                   out_payload_tag, last_of_run
//  config    cfg_wr_en              cfg_wr_data (channel_mode)
//
// After reset a clearing pass over all NUM_STREAMS * REORDER_WINDOW slots holds msg_stall high.
// An item is loaded in the idle state, which starts the registered read of its stream state;
// the evaluate state then issues a single result, or an ack that the second state follows
// with a delivery, or, for an in-order reliable-ordered message, a delivery that the drain
// state follows with one beat per drained entry and a closing ack. A stalled result beat holds the
// sequencer; the next message is taken once the last beat of the current one is issued.
module sequenced_channel_receive_reorder_top #(
  parameter int NUM_STREAMS    = scrr_pkg::NUM_STREAMS_DEFAULT,
  parameter int REORDER_WINDOW = scrr_pkg::REORDER_WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          msg_valid,
  output logic                          msg_stall,
  input  logic [scrr_pkg::STREAM_W-1:0] stream_index,
  input  logic [scrr_pkg::SEQ_W-1:0]    msg_sequence,
  input  logic [scrr_pkg::ID_W-1:0]     message_id,
  input  logic [scrr_pkg::TAG_W-1:0]    payload_tag,
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_wr_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          result_kind,
  output logic [scrr_pkg::STREAM_W-1:0] out_stream,
  output logic [scrr_pkg::SEQ_W-1:0]    out_sequence,
  output logic [scrr_pkg::ID_W-1:0]     out_message_id,
  output logic [scrr_pkg::TAG_W-1:0]    out_payload_tag,
  output logic                          last_of_run
);

  scrr_pkg::cmd_t    cmd;
  scrr_pkg::status_t sts;

  scrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scrr_dpath #(
    .NUM_STREAMS    (NUM_STREAMS),
    .REORDER_WINDOW (REORDER_WINDOW)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .stream_index    (stream_index),
    .msg_sequence    (msg_sequence),
    .message_id      (message_id),
    .payload_tag     (payload_tag),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .result_kind     (result_kind),
    .out_stream      (out_stream),
    .out_sequence    (out_sequence),
    .out_message_id  (out_message_id),
    .out_payload_tag (out_payload_tag),
    .last_of_run     (last_of_run)
  );

endmodule
